@@ rtl/u2a_pkg.sv @@
// Shared types, sizes and the transliteration table of the UTF-8 to ASCII block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package u2a_pkg;

  // Field widths.
  localparam int BYTE_W = 8;
  localparam int CHAR_W = 7;
  localparam int LEN_W  = 16;
  localparam int CP_W   = 21;
  localparam int REM_W  = 2;

  // Longest replacement, in characters.
  localparam int MAX_REP = 3;
  localparam int NREP_W  = 2;

  // Job queue between the front and the back.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // Output size after reset.
  localparam logic [LEN_W-1:0] OUT_SIZE_RST = 16'd64;

  // Action codes of the input item.
  localparam logic ACT_DATA = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // Lead byte patterns.
  localparam logic [2:0] LEAD2_PAT = 3'b110;
  localparam logic [3:0] LEAD3_PAT = 4'b1110;
  localparam logic [4:0] LEAD4_PAT = 5'b11110;

  localparam logic [BYTE_W-1:0] UNKNOWN_CHAR = "?";

  // A replacement: 0 to 3 characters, the first in chars[0].
  typedef struct packed {
    logic [NREP_W-1:0]               len;
    logic [MAX_REP-1:0][CHAR_W-1:0]  chars;
  } xlat_t;

  // One unit of work for the back: the characters to emit, whether the
  // string closes after them, and the length before the first of them.
  typedef struct packed {
    logic [MAX_REP-1:0][CHAR_W-1:0]  chars;
    logic [NREP_W-1:0]               nchar;
    logic                            term;
    logic [LEN_W-1:0]                base;
  } job_t;

  function automatic xlat_t xl_none();
    xlat_t r;
    r = '0;
    return r;
  endfunction

  function automatic xlat_t xl_one(input logic [BYTE_W-1:0] a);
    xlat_t r;
    r          = '0;
    r.len      = 2'd1;
    r.chars[0] = a[CHAR_W-1:0];
    return r;
  endfunction

  function automatic xlat_t xl_two(input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] b);
    xlat_t r;
    r          = '0;
    r.len      = 2'd2;
    r.chars[0] = a[CHAR_W-1:0];
    r.chars[1] = b[CHAR_W-1:0];
    return r;
  endfunction

  function automatic xlat_t xl_three(input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] b,
                                     input logic [BYTE_W-1:0] c);
    xlat_t r;
    r          = '0;
    r.len      = 2'd3;
    r.chars[0] = a[CHAR_W-1:0];
    r.chars[1] = b[CHAR_W-1:0];
    r.chars[2] = c[CHAR_W-1:0];
    return r;
  endfunction

  // Transliteration of Polish, Russian and Ukrainian letters. Anything not
  // listed becomes a question mark; the hard and soft signs vanish.
  function automatic xlat_t xlat_lookup(input logic [CP_W-1:0] cp);
    xlat_t r;
    unique case (cp)
      21'h000104: r = xl_one("A");   21'h000105: r = xl_one("a");
      21'h000106: r = xl_one("C");   21'h000107: r = xl_one("c");
      21'h000118: r = xl_one("E");   21'h000119: r = xl_one("e");
      21'h000141: r = xl_one("L");   21'h000142: r = xl_one("l");
      21'h000143: r = xl_one("N");   21'h000144: r = xl_one("n");
      21'h0000D3: r = xl_one("O");   21'h0000F3: r = xl_one("o");
      21'h00015A: r = xl_one("S");   21'h00015B: r = xl_one("s");
      21'h000179: r = xl_one("Z");   21'h00017A: r = xl_one("z");
      21'h00017B: r = xl_one("Z");   21'h00017C: r = xl_one("z");
      21'h000410: r = xl_one("A");   21'h000430: r = xl_one("a");
      21'h000411: r = xl_one("B");   21'h000431: r = xl_one("b");
      21'h000412: r = xl_one("V");   21'h000432: r = xl_one("v");
      21'h000413: r = xl_one("G");   21'h000433: r = xl_one("g");
      21'h000414: r = xl_one("D");   21'h000434: r = xl_one("d");
      21'h000415: r = xl_one("E");   21'h000435: r = xl_one("e");
      21'h000401: r = xl_one("E");   21'h000451: r = xl_one("e");
      21'h000416: r = xl_two("Z", "h");   21'h000436: r = xl_two("z", "h");
      21'h000417: r = xl_one("Z");   21'h000437: r = xl_one("z");
      21'h000418: r = xl_one("I");   21'h000438: r = xl_one("i");
      21'h000419: r = xl_one("J");   21'h000439: r = xl_one("j");
      21'h00041A: r = xl_one("K");   21'h00043A: r = xl_one("k");
      21'h00041B: r = xl_one("L");   21'h00043B: r = xl_one("l");
      21'h00041C: r = xl_one("M");   21'h00043C: r = xl_one("m");
      21'h00041D: r = xl_one("N");   21'h00043D: r = xl_one("n");
      21'h00041E: r = xl_one("O");   21'h00043E: r = xl_one("o");
      21'h00041F: r = xl_one("P");   21'h00043F: r = xl_one("p");
      21'h000420: r = xl_one("R");   21'h000440: r = xl_one("r");
      21'h000421: r = xl_one("S");   21'h000441: r = xl_one("s");
      21'h000422: r = xl_one("T");   21'h000442: r = xl_one("t");
      21'h000423: r = xl_one("U");   21'h000443: r = xl_one("u");
      21'h000424: r = xl_one("F");   21'h000444: r = xl_one("f");
      21'h000425: r = xl_two("K", "h");   21'h000445: r = xl_two("k", "h");
      21'h000426: r = xl_two("T", "s");   21'h000446: r = xl_two("t", "s");
      21'h000427: r = xl_two("C", "h");   21'h000447: r = xl_two("c", "h");
      21'h000428: r = xl_two("S", "h");   21'h000448: r = xl_two("s", "h");
      21'h000429: r = xl_three("S", "c", "h");
      21'h000449: r = xl_three("s", "c", "h");
      21'h00042A: r = xl_none();     21'h00044A: r = xl_none();
      21'h00042B: r = xl_one("Y");   21'h00044B: r = xl_one("y");
      21'h00042C: r = xl_none();     21'h00044C: r = xl_none();
      21'h00042D: r = xl_one("E");   21'h00044D: r = xl_one("e");
      21'h00042E: r = xl_two("Y", "u");   21'h00044E: r = xl_two("y", "u");
      21'h00042F: r = xl_two("Y", "a");   21'h00044F: r = xl_two("y", "a");
      21'h000404: r = xl_two("Y", "e");   21'h000454: r = xl_two("y", "e");
      21'h000406: r = xl_one("I");   21'h000456: r = xl_one("i");
      21'h000407: r = xl_two("Y", "i");   21'h000457: r = xl_two("y", "i");
      21'h000490: r = xl_one("G");   21'h000491: r = xl_one("g");
      default:    r = xl_one(UNKNOWN_CHAR);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/u2a_front.sv @@
// Front end: accepts bytes, gathers UTF-8 sequences, transliterates them and
// checks each replacement against the output size. Depends on u2a_pkg.
`default_nettype none

module u2a_front (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_accept,
  input  wire                       in_action,
  input  wire [u2a_pkg::BYTE_W-1:0] in_byte,
  input  wire                       cfg_wr,
  input  wire [u2a_pkg::LEN_W-1:0]  cfg_out_size,
  output logic                      q_wr,
  output u2a_pkg::job_t             q_job
);
  import u2a_pkg::*;

  logic [CP_W-1:0]  pc_r, pc_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic             stop_r, stop_nxt;
  logic [LEN_W-1:0] size_r;

  logic             term;
  logic             map_en;
  logic             asc_en;
  logic [CP_W-1:0]  map_cp;
  logic [CP_W-1:0]  shifted;
  xlat_t            looked;
  xlat_t            rep;
  logic             fit;
  logic             emit;
  logic             refuse;

  // Sequence assembly: decides what, if anything, this item asks to emit.
  always_comb begin
    pc_nxt  = pc_r;
    rem_nxt = rem_r;
    term    = 1'b0;
    map_en  = 1'b0;
    asc_en  = 1'b0;
    shifted = {pc_r[CP_W-7:0], in_byte[5:0]};
    map_cp  = pc_r;
    if (in_accept) begin
      if (in_action == ACT_END) begin
        term    = 1'b1;
        map_en  = (rem_r != '0);
        pc_nxt  = '0;
        rem_nxt = '0;
      end else if (in_byte != '0) begin
        priority if (rem_r != '0) begin
          pc_nxt  = shifted;
          rem_nxt = rem_r - 2'd1;
          map_en  = (rem_r == 2'd1);
          map_cp  = shifted;
        end else if (!in_byte[7]) begin
          asc_en = 1'b1;
        end else if (in_byte[7:5] == LEAD2_PAT) begin
          pc_nxt  = {16'd0, in_byte[4:0]};
          rem_nxt = 2'd1;
        end else if (in_byte[7:4] == LEAD3_PAT) begin
          pc_nxt  = {17'd0, in_byte[3:0]};
          rem_nxt = 2'd2;
        end else if (in_byte[7:3] == LEAD4_PAT) begin
          pc_nxt  = {18'd0, in_byte[2:0]};
          rem_nxt = 2'd3;
        end else begin
          // Stray continuation or invalid lead byte: dropped.
          pc_nxt = pc_r;
        end
      end
    end
  end

  // Replacement selection and the capacity check.
  always_comb begin
    looked = xlat_lookup(map_cp);
    if (asc_en) begin
      rep = xl_one(in_byte);
    end else if (map_en) begin
      rep = looked;
    end else begin
      rep = xl_none();
    end
    fit    = ({1'b0, cnt_r} + (LEN_W+1)'(rep.len) + (LEN_W+1)'(1)) <= {1'b0, size_r};
    emit   = !stop_r && (rep.len != '0) && fit;
    refuse = !stop_r && (rep.len != '0) && !fit;
    if (term) begin
      cnt_nxt  = '0;
      stop_nxt = 1'b0;
    end else begin
      cnt_nxt  = emit ? cnt_r + LEN_W'(rep.len) : cnt_r;
      stop_nxt = stop_r | refuse;
    end
  end

  // Request toward the job queue.
  always_comb begin
    q_job.chars = rep.chars;
    q_job.nchar = emit ? rep.len : '0;
    q_job.term  = term;
    q_job.base  = cnt_r;
    q_wr        = in_accept && (emit || term);
  end

  // String state and the size register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      rem_r  <= '0;
      cnt_r  <= '0;
      stop_r <= 1'b0;
      size_r <= OUT_SIZE_RST;
    end else begin
      pc_r   <= pc_nxt;
      rem_r  <= rem_nxt;
      cnt_r  <= cnt_nxt;
      stop_r <= stop_nxt;
      if (cfg_wr) begin
        size_r <= cfg_out_size;
      end
    end
  end

  // The end item leaves a clean string state.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_action == ACT_END) |=> (cnt_r == '0 && !stop_r && rem_r == '0))
    else $error("string state not cleared after end item");

  // Only the end item may send a job without characters.
  a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (q_wr && !q_job.term) |-> (q_job.nchar != '0))
    else $error("empty job queued");

  // Once stopped, no characters are queued until the string ends.
  a_stop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (stop_r && q_wr) |-> (q_job.nchar == '0))
    else $error("characters emitted after refusal");

endmodule

`default_nettype wire

@@ rtl/u2a_queue.sv @@
// Small job queue that decouples the front end from the result sequencer.
// Depends on u2a_pkg for the job type and depth.
`default_nettype none

module u2a_queue (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            wr,
  input  u2a_pkg::job_t  wr_job,
  input  wire            rd,
  output u2a_pkg::job_t  rd_job,
  output logic           full,
  output logic           empty
);
  import u2a_pkg::*;

  job_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r;
  logic [Q_AW-1:0] rp_r;
  logic [Q_CW-1:0] count_r;

  assign full   = (count_r == Q_CW'(Q_DEPTH));
  assign empty  = (count_r == '0);
  assign rd_job = mem_r[rp_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= wr_job;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      if (wr) begin
        wp_r <= wp_r + Q_AW'(1);
      end
      if (rd) begin
        rp_r <= rp_r + Q_AW'(1);
      end
      if (wr && !rd) begin
        count_r <= count_r + Q_CW'(1);
      end else if (rd && !wr) begin
        count_r <= count_r - Q_CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr |-> (!full || rd))
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd |-> !empty)
    else $error("job queue underflow");

endmodule

`default_nettype wire

@@ rtl/u2a_back.sv @@
// Result sequencer: takes jobs from the queue and presents their results on
// the output queue interface, one per cycle while pop is high. Depends on u2a_pkg.
`default_nettype none

module u2a_back (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       q_empty,
  input  u2a_pkg::job_t             q_job,
  output logic                      q_rd,
  input  wire                       pop,
  output logic                      empty,
  output logic [u2a_pkg::CHAR_W-1:0] out_char,
  output logic                      out_terminator,
  output logic [u2a_pkg::LEN_W-1:0] out_length,
  output logic                      out_last
);
  import u2a_pkg::*;

  job_t              cur_r;
  logic              cur_v_r;
  logic [NREP_W-1:0] idx_r;

  logic [NREP_W:0]   total;
  logic [NREP_W-1:0] last_idx;
  logic              is_char;
  logic              final_res;
  logic              advance;
  logic [NREP_W:0]   len_add;

  // Position within the current job.
  always_comb begin
    total     = {1'b0, cur_r.nchar} + {{NREP_W{1'b0}}, cur_r.term};
    last_idx  = NREP_W'(total - (NREP_W+1)'(1));
    is_char   = (idx_r < cur_r.nchar);
    final_res = (idx_r == last_idx);
    advance   = pop && cur_v_r;
    q_rd      = !q_empty && (!cur_v_r || (advance && final_res));
  end

  // Result fields from the current job.
  always_comb begin
    empty = !cur_v_r;
    if (is_char) begin
      unique case (idx_r)
        2'd0:    out_char = cur_r.chars[0];
        2'd1:    out_char = cur_r.chars[1];
        default: out_char = cur_r.chars[2];
      endcase
      len_add        = {1'b0, idx_r} + (NREP_W+1)'(1);
      out_terminator = 1'b0;
      out_last       = !cur_r.term && (idx_r == cur_r.nchar - NREP_W'(1));
    end else begin
      out_char       = '0;
      len_add        = {1'b0, cur_r.nchar};
      out_terminator = 1'b1;
      out_last       = 1'b1;
    end
    out_length = cur_r.base + LEN_W'(len_add);
  end

  // Job register and result index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      idx_r   <= '0;
    end else if (q_rd) begin
      cur_v_r <= 1'b1;
      idx_r   <= '0;
    end else if (advance) begin
      if (final_res) begin
        cur_v_r <= 1'b0;
        idx_r   <= '0;
      end else begin
        idx_r <= idx_r + NREP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur_r <= q_job;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_v_r |-> (idx_r <= last_idx))
    else $error("result index past end of job");

  a_job_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cur_v_r |-> (cur_r.nchar != '0 || cur_r.term))
    else $error("sequencer holds an empty job");

endmodule

`default_nettype wire

@@ rtl/utf8_to_ascii_transliterator.sv @@
// Top level of the UTF-8 to ASCII transliterator.
// Instantiates u2a_front, u2a_queue and u2a_back; depends on u2a_pkg.
`default_nettype none

// Bytes of a UTF-8 string enter through push/full, one per cycle while full
// is low, and the string is closed by an item with in_action high. Nonzero
// ASCII bytes pass through, two- to four-byte sequences are transliterated to
// zero to three Latin letters (unknown letters give '?'), and the end item
// yields a terminator result carrying the string length. Results leave
// through empty/pop, one per cycle while pop is high. The front end handles
// every byte in the cycle it is accepted; an item yields 0 to 3 results (up
// to 4 for an end item closing a truncated sequence), and sustained throughput
// is bounded by the one-result-per-cycle result sequencer. A four-entry job
// queue absorbs short bursts. cfg_ready is always high; change the output size
// only while no string is in flight. There is no initialization period after
// reset.
module utf8_to_ascii_transliterator (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        push,
  output logic                       full,
  input  wire                        in_action,
  input  wire [u2a_pkg::BYTE_W-1:0]  in_byte,
  output logic                       empty,
  input  wire                        pop,
  output logic [u2a_pkg::CHAR_W-1:0] out_char,
  output logic                       out_terminator,
  output logic [u2a_pkg::LEN_W-1:0]  out_length,
  output logic                       out_last,
  input  wire                        cfg_valid,
  output logic                       cfg_ready,
  input  wire [u2a_pkg::LEN_W-1:0]   cfg_out_size
);
  import u2a_pkg::*;

  logic  in_accept;
  logic  q_wr;
  logic  q_rd;
  logic  q_empty;
  job_t  wr_job;
  job_t  rd_job;

  assign cfg_ready = 1'b1;
  assign in_accept = push && !full;

  u2a_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_accept    (in_accept),
    .in_action    (in_action),
    .in_byte      (in_byte),
    .cfg_wr       (cfg_valid && cfg_ready),
    .cfg_out_size (cfg_out_size),
    .q_wr         (q_wr),
    .q_job        (wr_job)
  );

  u2a_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (q_wr),
    .wr_job (wr_job),
    .rd     (q_rd),
    .rd_job (rd_job),
    .full   (full),
    .empty  (q_empty)
  );

  u2a_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_job          (rd_job),
    .q_rd           (q_rd),
    .pop            (pop),
    .empty          (empty),
    .out_char       (out_char),
    .out_terminator (out_terminator),
    .out_length     (out_length),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

@@ tb/utf8_to_ascii_transliterator_tb.sv @@
// Self-checking testbench of the UTF-8 to ASCII transliterator.
// Depends on u2a_pkg and utf8_to_ascii_transliterator; needs nothing else.
`timescale 1ns / 100ps

module utf8_to_ascii_transliterator_tb;
  import u2a_pkg::*;

  localparam int WATCHDOG = 2000;
  localparam int SETTLE   = 12;
  localparam int NPHASE   = 6;

  // One request for the input side; typed rows carry their single result.
  typedef struct packed {
    logic              act;
    logic [BYTE_W-1:0] dat;
    logic              typed;
    logic [CHAR_W-1:0] t_ch;
    logic              t_term;
    logic [LEN_W-1:0]  t_len;
  } byte_req_t;

  // One result as it leaves the block.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              term;
    logic [LEN_W-1:0]  len;
    logic              last;
  } ascii_out_t;

  logic              clk;
  logic              rst_n;
  logic              push;
  logic              full;
  logic              in_action;
  logic [BYTE_W-1:0] in_byte;
  logic              empty;
  logic              pop;
  logic [CHAR_W-1:0] out_char;
  logic              out_terminator;
  logic [LEN_W-1:0]  out_length;
  logic              out_last;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [LEN_W-1:0]  cfg_out_size;

  utf8_to_ascii_transliterator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_action      (in_action),
    .in_byte        (in_byte),
    .empty          (empty),
    .pop            (pop),
    .out_char       (out_char),
    .out_terminator (out_terminator),
    .out_length     (out_length),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_out_size   (cfg_out_size)
  );

  // Predictor state: a copy of the decoder and of the output size register.
  logic [CP_W-1:0]  cp_acc;
  logic [REM_W-1:0] seq_left;
  logic [LEN_W-1:0] char_count;
  logic             out_blocked;
  logic [LEN_W-1:0] buf_size;

  ascii_out_t byte_results[$];
  ascii_out_t ascii_due[$];
  byte_req_t  byte_feed[$];
  byte_req_t  cur_req;

  int  fails;
  int  items_in;
  int  live_items;
  int  results_out;
  int  stall_cycles;
  int  burst_left;
  int  gap_left;
  int  pop_tick;
  int  pop_mode;
  bit  in_taken;
  logic [15:0] pop_pat;

  // Polish letters and the Cyrillic letters outside the basic range 0x410 to 0x44F.
  logic [10:0] extra_cps [0:27] = '{
    11'h104, 11'h105, 11'h106, 11'h107, 11'h118, 11'h119, 11'h141, 11'h142,
    11'h143, 11'h144, 11'h0D3, 11'h0F3, 11'h15A, 11'h15B, 11'h179, 11'h17A,
    11'h17B, 11'h17C, 11'h401, 11'h451, 11'h404, 11'h454, 11'h406, 11'h456,
    11'h407, 11'h457, 11'h490, 11'h491
  };

  // Latin spelling of a codepoint; unknown ones become a question mark.
  function automatic string latin_of(input logic [CP_W-1:0] cp);
    case (cp)
      21'h104: return "A";   21'h105: return "a";   21'h106: return "C";
      21'h107: return "c";   21'h118: return "E";   21'h119: return "e";
      21'h141: return "L";   21'h142: return "l";   21'h143: return "N";
      21'h144: return "n";   21'h0D3: return "O";   21'h0F3: return "o";
      21'h15A: return "S";   21'h15B: return "s";   21'h179: return "Z";
      21'h17A: return "z";   21'h17B: return "Z";   21'h17C: return "z";
      21'h410: return "A";   21'h430: return "a";   21'h411: return "B";
      21'h431: return "b";   21'h412: return "V";   21'h432: return "v";
      21'h413: return "G";   21'h433: return "g";   21'h414: return "D";
      21'h434: return "d";   21'h415: return "E";   21'h435: return "e";
      21'h401: return "E";   21'h451: return "e";   21'h416: return "Zh";
      21'h436: return "zh";  21'h417: return "Z";   21'h437: return "z";
      21'h418: return "I";   21'h438: return "i";   21'h419: return "J";
      21'h439: return "j";   21'h41A: return "K";   21'h43A: return "k";
      21'h41B: return "L";   21'h43B: return "l";   21'h41C: return "M";
      21'h43C: return "m";   21'h41D: return "N";   21'h43D: return "n";
      21'h41E: return "O";   21'h43E: return "o";   21'h41F: return "P";
      21'h43F: return "p";   21'h420: return "R";   21'h440: return "r";
      21'h421: return "S";   21'h441: return "s";   21'h422: return "T";
      21'h442: return "t";   21'h423: return "U";   21'h443: return "u";
      21'h424: return "F";   21'h444: return "f";   21'h425: return "Kh";
      21'h445: return "kh";  21'h426: return "Ts";  21'h446: return "ts";
      21'h427: return "Ch";  21'h447: return "ch";  21'h428: return "Sh";
      21'h448: return "sh";  21'h429: return "Sch"; 21'h449: return "sch";
      21'h42A: return "";    21'h44A: return "";    21'h42B: return "Y";
      21'h44B: return "y";   21'h42C: return "";    21'h44C: return "";
      21'h42D: return "E";   21'h44D: return "e";   21'h42E: return "Yu";
      21'h44E: return "yu";  21'h42F: return "Ya";  21'h44F: return "ya";
      21'h404: return "Ye";  21'h454: return "ye";  21'h406: return "I";
      21'h456: return "i";   21'h407: return "Yi";  21'h457: return "yi";
      21'h490: return "G";   21'h491: return "g";
      default: return "?";
    endcase
  endfunction

  // A replacement goes out whole if it fits with the terminator, else output stops.
  function automatic void emit_latin(input string rep);
    ascii_out_t r;
    byte        c;
    int         n;
    n = rep.len();
    if (out_blocked || n == 0) return;
    if (int'(char_count) + n + 1 > int'(buf_size)) begin
      out_blocked = 1'b1;
      return;
    end
    for (int j = 0; j < n; j++) begin
      c            = rep[j];
      char_count   = char_count + 1'b1;
      r.ch         = c[CHAR_W-1:0];
      r.term       = 1'b0;
      r.len        = char_count;
      r.last       = 1'b0;
      byte_results.push_back(r);
    end
  endfunction

  // Works out the results of one accepted request; quiet marks an ignored byte.
  function automatic void transliterate_byte(input logic act, input logic [BYTE_W-1:0] b,
                                             output bit quiet);
    ascii_out_t r;
    byte_results.delete();
    quiet = 1'b0;
    if (act == ACT_END) begin
      if (seq_left != 0 && !out_blocked) emit_latin(latin_of(cp_acc));
      r.ch   = '0;
      r.term = 1'b1;
      r.len  = char_count;
      r.last = 1'b0;
      byte_results.push_back(r);
      cp_acc      = '0;
      seq_left    = '0;
      char_count  = '0;
      out_blocked = 1'b0;
    end else if (out_blocked || b == 0) begin
      quiet = 1'b1;
    end else if (seq_left != 0) begin
      // Any nonzero byte inside a sequence adds its low six bits.
      cp_acc   = {cp_acc[CP_W-7:0], b[5:0]};
      seq_left = seq_left - 1'b1;
      if (seq_left == 0) emit_latin(latin_of(cp_acc));
    end else if (!b[7]) begin
      emit_latin($sformatf("%c", b));
    end else if (b[7:5] == LEAD2_PAT) begin
      cp_acc   = CP_W'(b[4:0]);
      seq_left = 2'd1;
    end else if (b[7:4] == LEAD3_PAT) begin
      cp_acc   = CP_W'(b[3:0]);
      seq_left = 2'd2;
    end else if (b[7:3] == LEAD4_PAT) begin
      cp_acc   = CP_W'(b[2:0]);
      seq_left = 2'd3;
    end else begin
      quiet = 1'b1;
    end
    if (byte_results.size() > 0) byte_results[byte_results.size()-1].last = 1'b1;
  endfunction

  function automatic byte_req_t row(input logic act, input logic [BYTE_W-1:0] dat,
                                    input logic typed = 1'b0,
                                    input logic [CHAR_W-1:0] ch = '0,
                                    input logic term = 1'b0,
                                    input logic [LEN_W-1:0] len = '0);
    byte_req_t q;
    q.act    = act;
    q.dat    = dat;
    q.typed  = typed;
    q.t_ch   = ch;
    q.t_term = term;
    q.t_len  = len;
    return q;
  endfunction

  function automatic void feed_byte(input logic [BYTE_W-1:0] b);
    byte_feed.push_back(row(ACT_DATA, b));
  endfunction

  // Queues one random string: mostly well-formed letters, some noise, then the end.
  function automatic void queue_string();
    int          nseg;
    int          pick;
    logic [10:0] cp;
    nseg = $urandom_range(0, 10);
    for (int s = 0; s < nseg; s++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        feed_byte(8'($urandom_range(1, 127)));
      end else if (pick < 60) begin
        if ($urandom_range(0, 1) == 0) cp = 11'h410 + 11'($urandom_range(0, 63));
        else cp = extra_cps[$urandom_range(0, 27)];
        feed_byte({3'b110, cp[10:6]});
        feed_byte({2'b10, cp[5:0]});
      end else if (pick < 70) begin
        feed_byte({4'b1110, 4'($urandom)});
        repeat (2) feed_byte({2'b10, 6'($urandom)});
      end else if (pick < 76) begin
        feed_byte({5'b11110, 3'($urandom)});
        repeat (3) feed_byte({2'b10, 6'($urandom)});
      end else if (pick < 82) begin
        feed_byte({3'b110, 5'($urandom)});
        feed_byte({2'b10, 6'($urandom)});
      end else if (pick < 88) begin
        // Often broken sequence: a lead byte followed by zero to two nonzero bytes of any kind.
        feed_byte(8'($urandom_range(8'hC0, 8'hF7)));
        repeat ($urandom_range(0, 2)) feed_byte(8'($urandom_range(1, 255)));
      end else if (pick < 94) begin
        if ($urandom_range(0, 1) == 0) feed_byte(8'($urandom_range(8'h80, 8'hBF)));
        else feed_byte(8'($urandom_range(8'hF8, 8'hFF)));
      end else if (pick < 96) begin
        feed_byte(8'h00);
      end else begin
        feed_byte(8'($urandom_range(1, 255)));
      end
    end
    byte_feed.push_back(row(ACT_END, 8'($urandom_range(0, 255))));
  endfunction

  // Waits until every request is taken and every result is back, then lets the block settle.
  task automatic drain();
    while (byte_feed.size() != 0 || push || ascii_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_out_size(input logic [LEN_W-1:0] v);
    @(negedge clk);
    cfg_valid    <= 1'b1;
    cfg_out_size <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sender: bursts of random length with random gaps, requests change at the falling edge.
  always @(negedge clk) begin
    if (rst_n) begin
      if (push && !in_taken) begin
        // The current request is still waiting for room.
      end else if (gap_left > 0) begin
        push     <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (byte_feed.size() > 0) begin
        cur_req = byte_feed.pop_front();
        push      <= 1'b1;
        in_action <= cur_req.act;
        in_byte   <= cur_req.dat;
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 8);
          gap_left   <= $urandom_range(0, 5);
        end
      end else begin
        push <= 1'b0;
      end
      in_taken = 1'b0;
    end
  end

  // Receiver: free running, a random pattern, or a sparse one, chosen at random.
  always @(negedge clk) begin
    if (rst_n) begin
      if (pop_tick % 64 == 0) begin
        pop_mode = $urandom_range(0, 2);
        pop_pat  = 16'($urandom) | 16'h0001;
      end
      case (pop_mode)
        0:       pop <= 1'b1;
        1:       pop <= pop_pat[pop_tick % 16];
        default: pop <= (pop_tick % 4 == 0);
      endcase
      pop_tick = pop_tick + 1;
    end
  end

  // Monitor: predicts on every accepted request and checks every accepted result.
  always @(posedge clk) begin : monitor
    ascii_out_t got;
    ascii_out_t want;
    bit         quiet;
    bit         busy;
    if (rst_n) begin
      busy = 1'b0;
      if (cfg_valid && cfg_ready) begin
        buf_size = cfg_out_size;
        busy     = 1'b1;
      end
      if (push && !full) begin
        transliterate_byte(cur_req.act, cur_req.dat, quiet);
        if (cur_req.typed) begin
          want.ch   = cur_req.t_ch;
          want.term = cur_req.t_term;
          want.len  = cur_req.t_len;
          want.last = 1'b1;
          ascii_due.push_back(want);
        end else begin
          foreach (byte_results[i]) ascii_due.push_back(byte_results[i]);
        end
        in_taken = 1'b1;
        items_in++;
        if (!quiet) live_items++;
        busy = 1'b1;
      end
      if (pop && !empty) begin
        got.ch   = out_char;
        got.term = out_terminator;
        got.len  = out_length;
        got.last = out_last;
        if (ascii_due.size() == 0) begin
          $display("%0t: result with nothing expected: char=%h term=%b len=%0d last=%b",
                   $time, got.ch, got.term, got.len, got.last);
          fails++;
        end else begin
          want = ascii_due.pop_front();
          if (got !== want) begin
            $display({"%0t: expected char=%h term=%b len=%0d last=%b, ",
                      "got char=%h term=%b len=%0d last=%b"},
                     $time, want.ch, want.term, want.len, want.last,
                     got.ch, got.term, got.len, got.last);
            fails++;
          end
        end
        results_out++;
        busy = 1'b1;
      end
      if (busy) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= WATCHDOG) begin
          $display("%0t: no progress for %0d cycles, %0d results outstanding",
                   $time, WATCHDOG, ascii_due.size());
          $display("utf8_to_ascii_transliterator: mismatch");
          $finish;
        end
      end
    end
  end

  // Main sequence: reset, directed table, then random strings under several sizes.
  initial begin : main
    byte_req_t        dir_tab [0:23];
    logic [LEN_W-1:0] sizes [0:NPHASE-1];
    int               target;

    rst_n        = 1'b0;
    push         = 1'b0;
    in_action    = ACT_DATA;
    in_byte      = '0;
    pop          = 1'b0;
    cfg_valid    = 1'b0;
    cfg_out_size = '0;
    cp_acc       = '0;
    seq_left     = '0;
    char_count   = '0;
    out_blocked  = 1'b0;
    buf_size     = OUT_SIZE_RST;
    fails        = 0;
    items_in     = 0;
    live_items   = 0;
    results_out  = 0;
    stall_cycles = 0;
    burst_left   = 1;
    gap_left     = 0;
    pop_tick     = 0;
    pop_mode     = 0;
    pop_pat      = 16'hFFFF;
    in_taken     = 1'b0;

    // Directed cases at the size after reset; typed rows give their one result.
    dir_tab = '{
      row(ACT_DATA, 8'h41, 1'b1, 7'h41, 1'b0, 16'd1),   // plain letter
      row(ACT_DATA, 8'h01, 1'b1, 7'h01, 1'b0, 16'd2),   // lowest byte
      row(ACT_DATA, 8'h7F, 1'b1, 7'h7F, 1'b0, 16'd3),   // highest ASCII
      row(ACT_DATA, 8'h80),                             // stray continuation
      row(ACT_DATA, 8'hFF),                             // invalid lead
      row(ACT_DATA, 8'hC4),
      row(ACT_DATA, 8'h85, 1'b1, CHAR_W'("a"), 1'b0, 16'd4),  // Polish a with ogonek
      row(ACT_DATA, 8'hD0),
      row(ACT_DATA, 8'hA9),                             // three-letter replacement
      row(ACT_DATA, 8'hD0),
      row(ACT_DATA, 8'hAA),                             // hard sign vanishes
      row(ACT_DATA, 8'hE2),
      row(ACT_DATA, 8'h82),
      row(ACT_DATA, 8'hAC, 1'b1, CHAR_W'("?"), 1'b0, 16'd8),  // unknown three-byte letter
      row(ACT_DATA, 8'hF0),
      row(ACT_DATA, 8'h9F),
      row(ACT_DATA, 8'h98),
      row(ACT_DATA, 8'h80, 1'b1, CHAR_W'("?"), 1'b0, 16'd9),  // four-byte sequence
      row(ACT_DATA, 8'h00),                             // zero byte is ignored
      row(ACT_DATA, 8'hC5),
      row(ACT_DATA, 8'h01, 1'b1, CHAR_W'("L"), 1'b0, 16'd10), // ASCII folded into a sequence
      row(ACT_DATA, 8'hD0),
      row(ACT_END,  8'h00),                             // truncated sequence at the end
      row(ACT_END,  8'hFF, 1'b1, 7'h00, 1'b1, 16'd0)    // empty string
    };
    sizes = '{16'hFFFF, 16'h0000, 16'd2, 16'd6, 16'($urandom_range(3, 30)), 16'd20};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) byte_feed.push_back(dir_tab[i]);
    drain();

    // Each phase sends a short run of strings; the tail of the last one is drained.
    for (int p = 0; p < NPHASE; p++) begin
      write_out_size(sizes[p]);
      target = items_in + 14;
      while (items_in < target) begin
        if (byte_feed.size() < 8) queue_string();
        @(posedge clk);
      end
      drain();
    end

    fails += ascii_due.size();
    $display("Ran %0d input bytes and ends (%0d not ignored) and checked %0d results,",
             items_in, live_items, results_out);
    $display("over %0d output sizes from 0 to 65535 plus the size after reset.", NPHASE);
    if (fails == 0) begin
      $display("utf8_to_ascii_transliterator: match");
    end else begin
      $display("utf8_to_ascii_transliterator: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/u2a_pkg.sv
rtl/u2a_front.sv
rtl/u2a_queue.sv
rtl/u2a_back.sv
rtl/utf8_to_ascii_transliterator.sv
tb/utf8_to_ascii_transliterator_tb.sv
